>>> hw/rtl/opl_pkg.sv
// shared types and constants for the operator symbol lexer
// depends on nothing; imported by the decoder, the output queue, the top level and the bench
package opl_pkg;

	// token codes that more than one place needs
	localparam logic [5:0] KIND_NONE = 6'd53;

	// operator characters
	localparam logic [7:0] CH_EQ    = 8'h3D; // '='
	localparam logic [7:0] CH_GT    = 8'h3E; // '>'
	localparam logic [7:0] CH_LT    = 8'h3C; // '<'
	localparam logic [7:0] CH_DOT   = 8'h2E; // '.'
	localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
	localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
	localparam logic [7:0] CH_AMP   = 8'h26; // '&'
	localparam logic [7:0] CH_BAR   = 8'h7C; // '|'

	// pending partial operator
	typedef enum logic [4:0] {
		PEND_IDLE   = 5'd0,
		PEND_EQ     = 5'd1,
		PEND_EXC    = 5'd2,
		PEND_MIN    = 5'd3,
		PEND_PLUS   = 5'd4,
		PEND_STAR   = 5'd5,
		PEND_SLASH  = 5'd6,
		PEND_AMP    = 5'd7,
		PEND_BAR    = 5'd8,
		PEND_CARET  = 5'd9,
		PEND_PCT    = 5'd10,
		PEND_DOT    = 5'd11,
		PEND_DOTDOT = 5'd12,
		PEND_LT     = 5'd13,
		PEND_LTEQ   = 5'd14,
		PEND_LTLT   = 5'd15,
		PEND_GT     = 5'd16,
		PEND_GTGT   = 5'd17
	} pend_t;

	// one result record
	typedef struct packed {
		logic [5:0] kind;
		logic [1:0] len;
		logic [7:0] pbyte;
		logic       last;
	} res_t;

	// everything one character produces
	typedef struct packed {
		logic [1:0] count;
		res_t       res0;
		res_t       res1;
		pend_t      pend_next;
	} step_t;

endpackage

>>> hw/rtl/operator_symbol_lexer_top.sv
// Operator symbol lexer: one character (or an end mark) per transfer, one token per transfer out.
// Each character is registered, decoded against the pending operator by shallow logic in
// the following cycle, and its zero to two results are placed in a four-place output
// queue. A new character is taken every cycle while the queue holds two records or fewer,
// so the input rate is one item per cycle, limited by the one-token-per-cycle output when
// characters produce two tokens and by stalls on the token side. An end item flushes any
// pending operator; with nothing pending it produces no token. Depends on opl_pkg,
// opl_decode and opl_out_queue.
module operator_symbol_lexer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_byte,
	input  logic       end_flag,
	output logic       token_valid,
	input  logic       token_stall,
	output logic [5:0] token_kind,
	output logic [1:0] token_length,
	output logic [7:0] passed_byte,
	output logic       last_result
);
	import opl_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	pend_t      pend_q;
	step_t      step;
	logic       room;
	logic       drain;
	logic       take;
	res_t       head;

	assign drain      = valid_s1 && room;
	assign char_stall = valid_s1 && !room;
	assign take       = char_valid && !char_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= char_byte;
			end_s1  <= end_flag;
		end
	end

	// pending operator advances as each registered item is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_IDLE;
		end else if (drain) begin
			pend_q <= step.pend_next;
		end
	end

	opl_decode u_decode (
		.pend    (pend_q),
		.char_in (char_s1),
		.end_in  (end_s1),
		.step    (step)
	);

	opl_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (drain ? step.count : 2'd0),
		.push0      (step.res0),
		.push1      (step.res1),
		.room       (room),
		.head_valid (token_valid),
		.head       (head),
		.head_stall (token_stall)
	);

	assign token_kind   = head.kind;
	assign token_length = head.len;
	assign passed_byte  = head.pbyte;
	assign last_result  = head.last;

endmodule

>>> hw/rtl/opl_decode.sv
// longest-match step: pending operator and one character in, up to two results out
// depends on opl_pkg
module opl_decode (
	input  opl_pkg::pend_t pend,
	input  logic [7:0]     char_in,
	input  logic           end_in,
	output opl_pkg::step_t step
);
	import opl_pkg::*;

	logic [5:0] fl_kind;
	logic [1:0] fl_len;
	logic       ext_done;
	logic       ext_hold;
	logic [5:0] ext_kind;
	pend_t      ext_pend;
	logic       fr_done;
	logic       fr_hold;
	logic [5:0] fr_kind;
	pend_t      fr_pend;
	res_t       flush_res;
	res_t       fresh_res;
	logic       lead;

	// token and length when the pending operator is flushed
	always_comb begin
		unique case (pend)
			PEND_EQ:     begin fl_kind = 6'd15; fl_len = 2'd1; end
			PEND_EXC:    begin fl_kind = 6'd18; fl_len = 2'd1; end
			PEND_MIN:    begin fl_kind = 6'd22; fl_len = 2'd1; end
			PEND_PLUS:   begin fl_kind = 6'd25; fl_len = 2'd1; end
			PEND_STAR:   begin fl_kind = 6'd27; fl_len = 2'd1; end
			PEND_SLASH:  begin fl_kind = 6'd29; fl_len = 2'd1; end
			PEND_AMP:    begin fl_kind = 6'd32; fl_len = 2'd1; end
			PEND_BAR:    begin fl_kind = 6'd35; fl_len = 2'd1; end
			PEND_CARET:  begin fl_kind = 6'd37; fl_len = 2'd1; end
			PEND_PCT:    begin fl_kind = 6'd39; fl_len = 2'd1; end
			PEND_DOT:    begin fl_kind = 6'd43; fl_len = 2'd1; end
			PEND_DOTDOT: begin fl_kind = 6'd42; fl_len = 2'd2; end
			PEND_LT:     begin fl_kind = 6'd48; fl_len = 2'd1; end
			PEND_LTEQ:   begin fl_kind = 6'd45; fl_len = 2'd2; end
			PEND_LTLT:   begin fl_kind = 6'd47; fl_len = 2'd2; end
			PEND_GT:     begin fl_kind = 6'd52; fl_len = 2'd1; end
			PEND_GTGT:   begin fl_kind = 6'd51; fl_len = 2'd2; end
			default:     begin fl_kind = 6'd0;  fl_len = 2'd0; end
		endcase
	end

	// can the character extend the pending operator
	always_comb begin
		ext_done = 1'b0;
		ext_hold = 1'b0;
		ext_kind = 6'd0;
		ext_pend = PEND_IDLE;
		unique case (pend)
			PEND_EQ: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd13; end
				else if (char_in == CH_GT) begin ext_done = 1'b1; ext_kind = 6'd14; end
			end
			PEND_EXC: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd17; end
			end
			PEND_MIN: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd19; end
				else if (char_in == CH_GT) begin ext_done = 1'b1; ext_kind = 6'd20; end
				else if (char_in == CH_MINUS) begin ext_done = 1'b1; ext_kind = 6'd21; end
			end
			PEND_PLUS: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd23; end
				else if (char_in == CH_PLUS) begin ext_done = 1'b1; ext_kind = 6'd24; end
			end
			PEND_STAR: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd26; end
			end
			PEND_SLASH: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd28; end
			end
			PEND_AMP: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd30; end
				else if (char_in == CH_AMP) begin ext_done = 1'b1; ext_kind = 6'd31; end
			end
			PEND_BAR: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd33; end
				else if (char_in == CH_BAR) begin ext_done = 1'b1; ext_kind = 6'd34; end
			end
			PEND_CARET: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd36; end
			end
			PEND_PCT: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd38; end
			end
			PEND_DOT: begin
				if (char_in == CH_DOT) begin ext_hold = 1'b1; ext_pend = PEND_DOTDOT; end
			end
			PEND_DOTDOT: begin
				if (char_in == CH_DOT) begin ext_done = 1'b1; ext_kind = 6'd40; end
				else if (char_in == CH_LT) begin ext_done = 1'b1; ext_kind = 6'd41; end
			end
			PEND_LT: begin
				if (char_in == CH_EQ) begin ext_hold = 1'b1; ext_pend = PEND_LTEQ; end
				else if (char_in == CH_LT) begin ext_hold = 1'b1; ext_pend = PEND_LTLT; end
			end
			PEND_LTEQ: begin
				if (char_in == CH_GT) begin ext_done = 1'b1; ext_kind = 6'd44; end
			end
			PEND_LTLT: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd46; end
			end
			PEND_GT: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd49; end
				else if (char_in == CH_GT) begin ext_hold = 1'b1; ext_pend = PEND_GTGT; end
			end
			PEND_GTGT: begin
				if (char_in == CH_EQ) begin ext_done = 1'b1; ext_kind = 6'd50; end
			end
			default: begin
				ext_done = 1'b0;
			end
		endcase
	end

	// classify the character from idle
	always_comb begin
		fr_done = 1'b1;
		fr_hold = 1'b0;
		fr_kind = 6'd0;
		fr_pend = PEND_IDLE;
		unique case (char_in)
			8'h27:    fr_kind = 6'd0;  // quote
			8'h5C:    fr_kind = 6'd1;  // backslash
			8'h28:    fr_kind = 6'd2;
			8'h29:    fr_kind = 6'd3;
			8'h5B:    fr_kind = 6'd4;
			8'h5D:    fr_kind = 6'd5;
			8'h7B:    fr_kind = 6'd6;
			8'h7D:    fr_kind = 6'd7;
			8'h3B:    fr_kind = 6'd8;
			8'h2C:    fr_kind = 6'd9;
			8'h40:    fr_kind = 6'd10;
			8'h3F:    fr_kind = 6'd11;
			8'h7E:    fr_kind = 6'd12;
			8'h3A:    fr_kind = 6'd16; // colon
			CH_EQ:    begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_EQ;    end
			8'h21:    begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_EXC;   end
			CH_MINUS: begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_MIN;   end
			CH_PLUS:  begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_PLUS;  end
			8'h2A:    begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_STAR;  end
			8'h2F:    begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_SLASH; end
			CH_AMP:   begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_AMP;   end
			CH_BAR:   begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_BAR;   end
			8'h5E:    begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_CARET; end
			8'h25:    begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_PCT;   end
			CH_DOT:   begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_DOT;   end
			CH_LT:    begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_LT;    end
			CH_GT:    begin fr_done = 1'b0; fr_hold = 1'b1; fr_pend = PEND_GT;    end
			default:  fr_done = 1'b0;
		endcase
	end

	// candidate records
	always_comb begin
		flush_res = '{kind: fl_kind, len: fl_len, pbyte: 8'd0, last: 1'b0};
		if (fr_done) begin
			fresh_res = '{kind: fr_kind, len: 2'd1, pbyte: 8'd0, last: 1'b1};
		end else begin
			fresh_res = '{kind: KIND_NONE, len: 2'd1, pbyte: char_in, last: 1'b1};
		end
	end

	assign lead = (pend != PEND_IDLE);

	// assemble the step
	always_comb begin
		step.count     = 2'd0;
		step.res0      = flush_res;
		step.res1      = fresh_res;
		step.pend_next = PEND_IDLE;
		if (end_in) begin
			// flush whatever is pending
			step.res0.last = 1'b1;
			step.count     = lead ? 2'd1 : 2'd0;
		end else if (lead && ext_done) begin
			step.res0  = '{kind: ext_kind, len: fl_len + 2'd1, pbyte: 8'd0, last: 1'b1};
			step.count = 2'd1;
		end else if (lead && ext_hold) begin
			step.pend_next = ext_pend;
		end else begin
			// flush pending if any, then the character starts over
			step.pend_next = fr_hold ? fr_pend : PEND_IDLE;
			if (lead) begin
				step.res0.last = fr_hold;
				step.count     = fr_hold ? 2'd1 : 2'd2;
			end else begin
				step.res0  = fresh_res;
				step.count = fr_hold ? 2'd0 : 2'd1;
			end
		end
	end

endmodule

>>> hw/rtl/opl_out_queue.sv
// four-place result queue: takes up to two records a cycle, hands out one
// depends on opl_pkg
module opl_out_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_count,
	input  opl_pkg::res_t push0,
	input  opl_pkg::res_t push1,
	output logic          room,
	output logic          head_valid,
	output opl_pkg::res_t head,
	input  logic          head_stall
);
	import opl_pkg::*;

	localparam int Depth = 4;

	res_t       slot_q [Depth];
	logic [2:0] count_q;
	logic       pop;
	logic [2:0] base;
	res_t       slot_d [Depth];
	logic [2:0] count_d;

	assign head_valid = (count_q != 3'd0);
	assign head       = slot_q[0];
	assign pop        = head_valid && !head_stall;
	// two places always free when the count is at most two
	assign room       = (count_q <= 3'd2);
	assign base       = count_q - {2'd0, pop};
	assign count_d    = base + {1'b0, push_count};

	// shift out the head on a transfer, append new records behind the rest
	always_comb begin
		for (int i = 0; i < Depth; i++) begin
			slot_d[i] = slot_q[i];
			if (3'(i) < base) begin
				if (pop && i < Depth - 1) begin
					slot_d[i] = slot_q[(i + 1) % Depth];
				end
			end else if (3'(i) == base && push_count != 2'd0) begin
				slot_d[i] = push0;
			end else if (3'(i) == base + 3'd1 && push_count == 2'd2) begin
				slot_d[i] = push1;
			end
		end
	end

	// payload places
	always_ff @(posedge clk) begin
		for (int i = 0; i < Depth; i++) begin
			slot_q[i] <= slot_d[i];
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else begin
			count_q <= count_d;
		end
	end

endmodule

>>> bench/operator_symbol_lexer_top_tb.sv
// self-checking bench for operator_symbol_lexer_top: longest-match token prediction
// depends on opl_pkg (pending-state enum, result record, operator characters) and the rtl
`timescale 1ns / 1ps

module operator_symbol_lexer_top_tb;
	import opl_pkg::*;

	// dense token codes in table order; the not-symbol code comes from the package
	typedef enum logic [5:0] {
		TK_QUOTE, TK_BSLASH, TK_LPAREN, TK_RPAREN, TK_LBRACK, TK_RBRACK, TK_LCURLY,
		TK_RCURLY, TK_SEMI, TK_COMMA, TK_AT, TK_QUEST, TK_TILDE, TK_EQEQ, TK_EQGT,
		TK_EQ, TK_COLON, TK_EXCEQ, TK_EXC, TK_MINEQ, TK_ARROW, TK_MINMIN, TK_MIN,
		TK_PLUSEQ, TK_PLUSPLUS, TK_PLUS, TK_STAREQ, TK_STAR, TK_SLASHEQ, TK_SLASH,
		TK_AMPEQ, TK_AMPAMP, TK_AMP, TK_BAREQ, TK_BARBAR, TK_BAR, TK_CARETEQ, TK_CARET,
		TK_PCTEQ, TK_PCT, TK_DOT3, TK_DOTDOTLT, TK_DOTDOT, TK_DOT, TK_SPACESHIP,
		TK_LTEQ, TK_LTLTEQ, TK_LTLT, TK_LT, TK_GTEQ, TK_GTGTEQ, TK_GTGT, TK_GT
	} tok_t;

	localparam logic [8:0] END_MARK = 9'h100;
	localparam int IDLE_PCT = 38;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_ITEMS = 400;

	// token predictor and queue of tokens still due
	class lexer_scoreboard;
		pend_t lex_pend;
		res_t  want_tokens[$];
		int    errors;

		function new();
			lex_pend = PEND_IDLE;
			errors = 0;
		endfunction

		// token produced when a pending operator is cut short
		function void flush_token(input pend_t p, output logic [5:0] kind,
				output logic [1:0] len);
			len = 2'd1;
			case (p)
				PEND_EQ:     kind = TK_EQ;
				PEND_EXC:    kind = TK_EXC;
				PEND_MIN:    kind = TK_MIN;
				PEND_PLUS:   kind = TK_PLUS;
				PEND_STAR:   kind = TK_STAR;
				PEND_SLASH:  kind = TK_SLASH;
				PEND_AMP:    kind = TK_AMP;
				PEND_BAR:    kind = TK_BAR;
				PEND_CARET:  kind = TK_CARET;
				PEND_PCT:    kind = TK_PCT;
				PEND_DOT:    kind = TK_DOT;
				PEND_DOTDOT: begin kind = TK_DOTDOT; len = 2'd2; end
				PEND_LT:     kind = TK_LT;
				PEND_LTEQ:   begin kind = TK_LTEQ; len = 2'd2; end
				PEND_LTLT:   begin kind = TK_LTLT; len = 2'd2; end
				PEND_GT:     kind = TK_GT;
				PEND_GTGT:   begin kind = TK_GTGT; len = 2'd2; end
				default:     kind = KIND_NONE;
			endcase
		endfunction

		function void add_token(input logic [5:0] kind, input logic [1:0] len,
				input logic [7:0] pb);
			res_t r;
			r.kind = kind;
			r.len = len;
			r.pbyte = pb;
			r.last = 1'b0;
			want_tokens.push_back(r);
		endfunction

		// one accepted character or end mark
		function void take_char(input logic [7:0] b, input logic is_end);
			logic [5:0] k;
			logic [1:0] fl;
			pend_t nxt;
			bit done, hold;
			int n0;
			n0 = want_tokens.size();
			done = 0;
			hold = 0;
			k = KIND_NONE;
			nxt = PEND_IDLE;
			flush_token(lex_pend, k, fl);
			if (is_end) begin
				if (lex_pend != PEND_IDLE)
					add_token(k, fl, 8'h00);
				lex_pend = PEND_IDLE;
			end else begin
				// try to grow the pending operator
				case (lex_pend)
					PEND_EQ:
						if (b == CH_EQ) begin done = 1; k = TK_EQEQ; end
						else if (b == CH_GT) begin done = 1; k = TK_EQGT; end
					PEND_EXC:
						if (b == CH_EQ) begin done = 1; k = TK_EXCEQ; end
					PEND_MIN:
						if (b == CH_EQ) begin done = 1; k = TK_MINEQ; end
						else if (b == CH_GT) begin done = 1; k = TK_ARROW; end
						else if (b == CH_MINUS) begin done = 1; k = TK_MINMIN; end
					PEND_PLUS:
						if (b == CH_EQ) begin done = 1; k = TK_PLUSEQ; end
						else if (b == CH_PLUS) begin done = 1; k = TK_PLUSPLUS; end
					PEND_STAR:
						if (b == CH_EQ) begin done = 1; k = TK_STAREQ; end
					PEND_SLASH:
						if (b == CH_EQ) begin done = 1; k = TK_SLASHEQ; end
					PEND_AMP:
						if (b == CH_EQ) begin done = 1; k = TK_AMPEQ; end
						else if (b == CH_AMP) begin done = 1; k = TK_AMPAMP; end
					PEND_BAR:
						if (b == CH_EQ) begin done = 1; k = TK_BAREQ; end
						else if (b == CH_BAR) begin done = 1; k = TK_BARBAR; end
					PEND_CARET:
						if (b == CH_EQ) begin done = 1; k = TK_CARETEQ; end
					PEND_PCT:
						if (b == CH_EQ) begin done = 1; k = TK_PCTEQ; end
					PEND_DOT:
						if (b == CH_DOT) begin hold = 1; nxt = PEND_DOTDOT; end
					PEND_DOTDOT:
						if (b == CH_DOT) begin done = 1; k = TK_DOT3; end
						else if (b == CH_LT) begin done = 1; k = TK_DOTDOTLT; end
					PEND_LT:
						if (b == CH_EQ) begin hold = 1; nxt = PEND_LTEQ; end
						else if (b == CH_LT) begin hold = 1; nxt = PEND_LTLT; end
					PEND_LTEQ:
						if (b == CH_GT) begin done = 1; k = TK_SPACESHIP; end
					PEND_LTLT:
						if (b == CH_EQ) begin done = 1; k = TK_LTLTEQ; end
					PEND_GT:
						if (b == CH_EQ) begin done = 1; k = TK_GTEQ; end
						else if (b == CH_GT) begin hold = 1; nxt = PEND_GTGT; end
					PEND_GTGT:
						if (b == CH_EQ) begin done = 1; k = TK_GTGTEQ; end
					default: ;
				endcase
				if (done) begin
					add_token(k, fl + 2'd1, 8'h00);
					lex_pend = PEND_IDLE;
				end else if (hold) begin
					lex_pend = nxt;
				end else begin
					// cut the pending operator short, then take the byte fresh
					if (lex_pend != PEND_IDLE)
						add_token(k, fl, 8'h00);
					lex_pend = PEND_IDLE;
					done = 1;
					case (b)
						"'":      k = TK_QUOTE;
						"\\":     k = TK_BSLASH;
						"(":      k = TK_LPAREN;
						")":      k = TK_RPAREN;
						"[":      k = TK_LBRACK;
						"]":      k = TK_RBRACK;
						"{":      k = TK_LCURLY;
						"}":      k = TK_RCURLY;
						";":      k = TK_SEMI;
						",":      k = TK_COMMA;
						"@":      k = TK_AT;
						"?":      k = TK_QUEST;
						"~":      k = TK_TILDE;
						":":      k = TK_COLON;
						CH_EQ:    begin done = 0; lex_pend = PEND_EQ; end
						"!":      begin done = 0; lex_pend = PEND_EXC; end
						CH_MINUS: begin done = 0; lex_pend = PEND_MIN; end
						CH_PLUS:  begin done = 0; lex_pend = PEND_PLUS; end
						"*":      begin done = 0; lex_pend = PEND_STAR; end
						"/":      begin done = 0; lex_pend = PEND_SLASH; end
						CH_AMP:   begin done = 0; lex_pend = PEND_AMP; end
						CH_BAR:   begin done = 0; lex_pend = PEND_BAR; end
						"^":      begin done = 0; lex_pend = PEND_CARET; end
						"%":      begin done = 0; lex_pend = PEND_PCT; end
						CH_DOT:   begin done = 0; lex_pend = PEND_DOT; end
						CH_LT:    begin done = 0; lex_pend = PEND_LT; end
						CH_GT:    begin done = 0; lex_pend = PEND_GT; end
						default:  k = KIND_NONE;
					endcase
					if (done)
						add_token(k, 2'd1, (k == KIND_NONE) ? b : 8'h00);
				end
			end
			// mark the final token of this item
			if (want_tokens.size() > n0)
				want_tokens[want_tokens.size() - 1].last = 1'b1;
		endfunction

		// one accepted token against the oldest one due
		function void check_token(input res_t got);
			res_t due;
			if (want_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected token kind %0d len %0d byte %02h last %0b",
					$time, got.kind, got.len, got.pbyte, got.last);
				return;
			end
			due = want_tokens.pop_front();
			if (got !== due) begin
				errors++;
				$display("%0t: token expected kind %0d len %0d byte %02h last %0b, %s",
					$time, due.kind, due.len, due.pbyte, due.last, "actual below");
				$display("%0t:       actual kind %0d len %0d byte %02h last %0b",
					$time, got.kind, got.len, got.pbyte, got.last);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       char_valid;
	logic       char_stall;
	logic [7:0] char_byte;
	logic       end_flag;
	logic       token_valid;
	logic       token_stall = 1'b0;
	logic [5:0] token_kind;
	logic [1:0] token_length;
	logic [7:0] passed_byte;
	logic       last_result;

	bit quiet = 1'b0;
	int idle_cycles = 0;
	lexer_scoreboard sb = new();

	logic [7:0] sym_chars[27] = '{"'", "\\", "(", ")", "[", "]", "{", "}", ";", ",",
		"@", "?", "~", ":", CH_EQ, "!", CH_MINUS, CH_PLUS, "*", "/", CH_AMP, CH_BAR,
		"^", "%", CH_DOT, CH_LT, CH_GT};
	logic [7:0] deep_chars[4] = '{CH_DOT, CH_LT, CH_GT, CH_EQ};

	// extremes, several three-character forms, flushes and cut-short operators
	logic [8:0] directed_seq[25] = '{
		9'h000, 9'h0FF, END_MARK,
		{1'b0, CH_LT}, {1'b0, CH_EQ}, {1'b0, CH_GT},
		{1'b0, CH_DOT}, {1'b0, CH_DOT}, {1'b0, CH_DOT},
		{1'b0, CH_DOT}, {1'b0, CH_DOT}, {1'b0, CH_LT},
		{1'b0, CH_GT}, {1'b0, CH_GT}, {1'b0, CH_EQ},
		{1'b0, CH_MINUS}, 9'h041,
		{1'b0, CH_EQ}, END_MARK,
		{1'b0, CH_LT}, {1'b0, CH_LT}, END_MARK,
		9'h021, 9'h021, END_MARK
	};

	operator_symbol_lexer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_byte    (char_byte),
		.end_flag     (end_flag),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_length (token_length),
		.passed_byte  (passed_byte),
		.last_result  (last_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random backpressure on the token side
	always @(posedge clk) begin
		token_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	// note every transfer on both sides
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (char_valid && !char_stall)
				sb.take_char(char_byte, end_flag);
			if (token_valid && !token_stall) begin
				got.kind = token_kind;
				got.len = token_length;
				got.pbyte = passed_byte;
				got.last = last_result;
				sb.check_token(got);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && !char_stall) || (token_valid && !token_stall))
				idle_cycles <= 0;
			else if (idle_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// present one item, with random idle cycles ahead of it
	task automatic send_item(input logic [7:0] b, input logic is_end);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_byte <= b;
		end_flag <= is_end;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
	endtask

	// hold off until every token due has arrived and the block has settled
	task automatic drain_tokens();
		char_valid <= 1'b0;
		// let the last transfer reach the scoreboard first
		@(posedge clk);
		while (sb.want_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sel;
		logic [7:0] b;
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_byte = 8'h00;
		end_flag = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_seq[i])
			send_item(directed_seq[i][7:0], directed_seq[i][8]);
		drain_tokens();

		// mostly operator characters to reach the deeper states, some noise and end marks
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 150 && i < 250);
			if (i == 300)
				drain_tokens();
			sel = $urandom_range(99);
			if (sel < 5)
				send_item(8'($urandom_range(255)), 1'b1);
			else begin
				if (sel < 30)
					b = 8'($urandom_range(255));
				else if (sel < 65)
					b = deep_chars[2'($urandom_range(3))];
				else
					b = sym_chars[5'($urandom_range(26))];
				send_item(b, 1'b0);
			end
		end
		send_item(8'($urandom_range(255)), 1'b1);
		drain_tokens();

		if (sb.errors == 0 && sb.want_tokens.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
